// ===== hw/rtl/asnorm_pkg.sv =====
// ----------------------------------------------------------------------------
// asnorm_pkg
// Shared types, codes and constants for the acceleration source selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asnorm_pkg;

  // Last emitted source, kept for duplicate suppression
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_LOW  = 2'd1,
    SRC_HIGH = 2'd2
  } src_e;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SQ    = 8'b0000_0010,
    ST_ROOT  = 8'b0000_0100,
    ST_SCL_R = 8'b0000_1000,
    ST_SCL_E = 8'b0001_0000,
    ST_SCL_P = 8'b0010_0000,
    ST_SCL_C = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  // Square-root unit status
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

  localparam logic [15:0] MaxAgeReset = 16'd50;

  // 9.80665 expressed as GDen / GNum
  localparam logic [31:0] GNum = 32'd100000;
  localparam logic [31:0] GDen = 32'd980665;

  // Reciprocal of 9.80665 scaled by 2^RecipShift; below 2^32
  localparam int          RecipShift = 35;
  localparam int          EstW       = 64 - RecipShift;
  localparam logic [63:0] GRecipWide =
    ((64'd1 << RecipShift) * 64'(GNum)) / 64'(GDen);
  localparam logic [31:0] GRecip     = GRecipWide[31:0];

  // Magnitude of a two's complement word; the most negative value gives 2^31
  function automatic logic [31:0] abs32(input logic [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/asnorm_mul.sv =====
// ----------------------------------------------------------------------------
// asnorm_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asnorm_mul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output      logic [63:0] prod_o
);

  logic [63:0] prod_q;
  logic [63:0] prod_d;

  assign prod_d = 64'(a_i) * 64'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== hw/rtl/asnorm_isqrt.sv =====
// ----------------------------------------------------------------------------
// asnorm_isqrt
// Digit-by-digit integer square root of a 64-bit word, one root bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asnorm_isqrt (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [63:0]            radicand_i,
  output      asnorm_pkg::sqrt_stat_t stat_o,
  output      logic [31:0]            root_o
);

  logic [63:0] rad_q, rad_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  logic [35:0] rem_sh;
  logic [35:0] trial;

  assign rem_sh = {rem_q, rad_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = 34'(rem_sh - trial);
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_sh[33:0];
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

`default_nettype wire

// ===== hw/rtl/accel_source_select_norm.sv =====
// ----------------------------------------------------------------------------
// accel_source_select_norm
// Low-g / high-g accelerometer source selection with vector magnitude in g.
// ----------------------------------------------------------------------------
// Each input transaction carries a low-g sample (m/s^2), a high-g sample (g),
// their timestamps and the current time. The low-g sample wins when its
// timestamp is nonzero and its modular age is at most max_age_ms; otherwise
// the high-g sample is used if it is healthy, connected, has new data and is
// equally fresh. A selection that repeats the source and timestamp of the
// last emitted result, or no qualifying sample at all, produces no output and
// the block is ready again on the next cycle. Otherwise one result follows:
// the magnitude is formed on a single shared 32 x 32 multiplier and a
// bit-serial square root, and a low-g magnitude is then scaled by 1/9.80665
// with a reciprocal multiply and a one-step correction. The square root takes
// most of the time from acceptance to the output register. Input stall stays
// high for the whole computation; a finished result waits in the output
// register, so the next transaction may be accepted before it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module accel_source_select_norm (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // input channel
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [31:0] low_accel_x_i,
  input  wire logic [31:0] low_accel_y_i,
  input  wire logic [31:0] low_accel_z_i,
  input  wire logic [31:0] low_time_ms_i,
  input  wire logic [31:0] high_accel_x_i,
  input  wire logic [31:0] high_accel_y_i,
  input  wire logic [31:0] high_accel_z_i,
  input  wire logic [31:0] high_time_ms_i,
  input  wire logic [1:0]  high_status_i,
  input  wire logic        high_health_ok_i,
  input  wire logic [31:0] now_ms_i,
  // output channel
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        source_o,
  output      logic [31:0] sample_time_o,
  output      logic [31:0] norm_g_o
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  asnorm_pkg::state_e state_q, state_d;
  asnorm_pkg::src_e   last_src_q, last_src_d;
  asnorm_pkg::src_e   src_q, src_d;

  logic [15:0] max_age_q, max_age_d;
  logic [31:0] last_time_q, last_time_d;
  logic [31:0] time_q, time_d;
  logic [31:0] comp_q [3];
  logic [31:0] comp_d [3];
  logic [1:0]  cnt_q, cnt_d;
  logic [63:0] acc_q, acc_d;
  logic [asnorm_pkg::EstW-1:0] est_q, est_d;
  logic [63:0] xq_q, xq_d;
  logic [31:0] norm_q, norm_d;

  logic        out_valid_q, out_valid_d;
  logic        out_src_q, out_src_d;
  logic [31:0] out_time_q, out_time_d;
  logic [31:0] out_norm_q, out_norm_d;

  // --------------------------------------------------------------------------
  // Selection, evaluated on the incoming transaction
  // --------------------------------------------------------------------------
  logic [31:0] low_age, high_age;
  logic        low_fresh, high_fresh, high_ok;
  logic        sel_any, dup, go;
  asnorm_pkg::src_e sel_src;
  logic [31:0] sel_time;
  logic        in_accept;

  assign low_age    = now_ms_i - low_time_ms_i;
  assign high_age   = now_ms_i - high_time_ms_i;
  assign low_fresh  = (low_time_ms_i != 32'd0) && (low_age <= {16'd0, max_age_q});
  assign high_fresh = (high_time_ms_i != 32'd0) && (high_age <= {16'd0, max_age_q});
  assign high_ok    = high_health_ok_i && high_status_i[0] && high_status_i[1]
                      && high_fresh;

  assign sel_any  = low_fresh || high_ok;
  assign sel_src  = low_fresh ? asnorm_pkg::SRC_LOW : asnorm_pkg::SRC_HIGH;
  assign sel_time = low_fresh ? low_time_ms_i : high_time_ms_i;
  // A repeat of the last emission is dropped; no fallback to high-g then
  assign dup      = (sel_src == last_src_q) && (sel_time == last_time_q);
  assign go       = sel_any && !dup;

  assign in_stall_o = (state_q != asnorm_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Shared multiplier and square-root unit
  // --------------------------------------------------------------------------
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        sqrt_start;
  logic [63:0] sqrt_rad;
  logic [31:0] root;
  logic [31:0] est_inc;
  asnorm_pkg::sqrt_stat_t sqrt_stat;

  assign est_inc = 32'(est_q) + 32'd1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      asnorm_pkg::ST_SQ: begin
        case (cnt_q)
          2'd0:    mul_a = comp_q[0];
          2'd1:    mul_a = comp_q[1];
          2'd2:    mul_a = comp_q[2];
          default: mul_a = '0;
        endcase
        mul_b = mul_a;
      end
      asnorm_pkg::ST_SCL_R: begin
        mul_a = root;
        mul_b = asnorm_pkg::GRecip;
      end
      asnorm_pkg::ST_SCL_E: begin
        mul_a = root;
        mul_b = asnorm_pkg::GNum;
      end
      asnorm_pkg::ST_SCL_P: begin
        mul_a = est_inc;
        mul_b = asnorm_pkg::GDen;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  asnorm_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign sqrt_start = (state_q == asnorm_pkg::ST_SQ) && (cnt_q == 2'd3);
  assign sqrt_rad   = acc_q + prod;

  asnorm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sqrt_rad),
    .stat_o     (sqrt_stat),
    .root_o     (root)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic out_free;
  logic emit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == asnorm_pkg::ST_DONE) && out_free;

  always_comb begin
    state_d     = state_q;
    max_age_d   = max_age_q;
    last_src_d  = last_src_q;
    last_time_d = last_time_q;
    src_d       = src_q;
    time_d      = time_q;
    comp_d      = comp_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    est_d       = est_q;
    xq_d        = xq_q;
    norm_d      = norm_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_src_d   = out_src_q;
    out_time_d  = out_time_q;
    out_norm_d  = out_norm_q;

    if (cfg_we_i) begin
      max_age_d = cfg_wdata_i;
    end

    case (state_q)
      asnorm_pkg::ST_IDLE: begin
        if (in_accept && go) begin
          src_d  = sel_src;
          time_d = sel_time;
          if (low_fresh) begin
            comp_d[0] = asnorm_pkg::abs32(low_accel_x_i);
            comp_d[1] = asnorm_pkg::abs32(low_accel_y_i);
            comp_d[2] = asnorm_pkg::abs32(low_accel_z_i);
          end else begin
            comp_d[0] = asnorm_pkg::abs32(high_accel_x_i);
            comp_d[1] = asnorm_pkg::abs32(high_accel_y_i);
            comp_d[2] = asnorm_pkg::abs32(high_accel_z_i);
          end
          cnt_d   = '0;
          acc_d   = '0;
          state_d = asnorm_pkg::ST_SQ;
        end
      end
      asnorm_pkg::ST_SQ: begin
        // issue one square a cycle, accumulate the previous product
        if (cnt_q != 2'd0) begin
          acc_d = acc_q + prod;
        end
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = asnorm_pkg::ST_ROOT;
        end
      end
      asnorm_pkg::ST_ROOT: begin
        if (sqrt_stat.done) begin
          if (src_q == asnorm_pkg::SRC_LOW) begin
            state_d = asnorm_pkg::ST_SCL_R;
          end else begin
            norm_d  = root;
            state_d = asnorm_pkg::ST_DONE;
          end
        end
      end
      asnorm_pkg::ST_SCL_R: begin
        state_d = asnorm_pkg::ST_SCL_E;
      end
      asnorm_pkg::ST_SCL_E: begin
        // estimate is the quotient or one below it
        est_d   = prod[63:asnorm_pkg::RecipShift];
        state_d = asnorm_pkg::ST_SCL_P;
      end
      asnorm_pkg::ST_SCL_P: begin
        xq_d    = prod;
        state_d = asnorm_pkg::ST_SCL_C;
      end
      asnorm_pkg::ST_SCL_C: begin
        // bump the estimate when (est + 1) * den still fits under the dividend
        norm_d  = (xq_q >= prod) ? est_inc : 32'(est_q);
        state_d = asnorm_pkg::ST_DONE;
      end
      asnorm_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_src_d   = (src_q == asnorm_pkg::SRC_HIGH);
          out_time_d  = time_q;
          out_norm_d  = norm_q;
          last_src_d  = src_q;
          last_time_d = time_q;
          state_d     = asnorm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = asnorm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asnorm_pkg::ST_IDLE;
      max_age_q   <= asnorm_pkg::MaxAgeReset;
      last_src_q  <= asnorm_pkg::SRC_NONE;
      last_time_q <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      max_age_q   <= max_age_d;
      last_src_q  <= last_src_d;
      last_time_q <= last_time_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    time_q     <= time_d;
    comp_q     <= comp_d;
    acc_q      <= acc_d;
    est_q      <= est_d;
    xq_q       <= xq_d;
    norm_q     <= norm_d;
    out_src_q  <= out_src_d;
    out_time_q <= out_time_d;
    out_norm_q <= out_norm_d;
  end

  assign out_valid_o   = out_valid_q;
  assign source_o      = out_src_q;
  assign sample_time_o = out_time_q;
  assign norm_g_o      = out_norm_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_root_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asnorm_pkg::ST_ROOT) |-> (sqrt_stat.busy || sqrt_stat.done))
    else $error("waiting on an idle square-root unit");

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && go) |=> (state_q == asnorm_pkg::ST_SQ))
    else $error("accepted transaction did not start the sequence");

  a_emit_records : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (out_valid_q && last_time_q == out_time_q
              && (last_src_q == asnorm_pkg::SRC_HIGH) == out_src_q))
    else $error("emitted result and last-emission record disagree");

  a_no_sqrt_outside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_stat.done |-> (state_q == asnorm_pkg::ST_ROOT))
    else $error("square-root result outside the root state");

endmodule

`default_nettype wire

// ===== tb/accel_source_select_norm_tb.sv =====
// ----------------------------------------------------------------------------
// accel_source_select_norm_tb
// Self-checking bench for the low-g / high-g source selector and magnitude.
// ----------------------------------------------------------------------------
// Drives sample transactions through the valid/stall input channel and keeps
// its own model of the selection rules and the fixed-point magnitude. Every
// accepted transaction is predicted on the spot. Every result taken from the
// output channel is compared field by field with the oldest prediction still
// waiting. A directed part covers the selection corner cases and the age
// limit extremes. Random traffic then runs under several idle and stall
// patterns and several age limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_source_select_norm_tb;

  // Bench timing
  localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before giving up
  localparam int DRAIN_CYCLES   = 64;    // longer than a low-g computation takes

  // High-g status bits
  localparam logic [1:0] STAT_NONE      = 2'b00;
  localparam logic [1:0] STAT_CONNECTED = 2'b01;
  localparam logic [1:0] STAT_NEW_DATA  = 2'b10;
  localparam logic [1:0] STAT_READY     = STAT_CONNECTED | STAT_NEW_DATA;

  // Conversion from m/s^2 to g: multiply by G_SCALE_NUM / G_SCALE_DEN
  localparam logic [63:0] G_SCALE_NUM = 64'd100000;
  localparam logic [63:0] G_SCALE_DEN = 64'd980665;

  // Handy Q16.16 words
  localparam logic [31:0] AXIS_MAX_POS   = 32'h7FFF_FFFF;
  localparam logic [31:0] AXIS_MOST_NEG  = 32'h8000_0000;
  localparam logic [31:0] AXIS_ONE_G_NEG = 32'(-642689);  // -9.80665 m/s^2
  localparam logic [31:0] AXIS_ONE       = 32'h0001_0000;

  typedef struct {
    logic [31:0] low_x;
    logic [31:0] low_y;
    logic [31:0] low_z;
    logic [31:0] low_t;
    logic [31:0] high_x;
    logic [31:0] high_y;
    logic [31:0] high_z;
    logic [31:0] high_t;
    logic [1:0]  status;
    logic        health;
    logic [31:0] now;
  } imu_sample_t;

  typedef struct {
    logic        source;
    logic [31:0] stamp;
    logic [31:0] norm;
  } selection_t;

  // --------------------------------------------------------------------------
  // Signals
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        in_valid_i  = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        source_o;
  logic [31:0] sample_time_o;
  logic [31:0] norm_g_o;

  // Payload under transfer; one struct so a transaction changes in one step
  imu_sample_t drive_sample;

  // Model state: register copy and duplicate-suppression memory
  logic [15:0]       age_limit       = asnorm_pkg::MaxAgeReset;
  asnorm_pkg::src_e  emitted_source  = asnorm_pkg::SRC_NONE;
  logic [31:0]       emitted_stamp   = 32'd0;

  // Predictions waiting for the matching result
  selection_t  expected_selections[$];
  selection_t  accepted_sel;
  selection_t  oldest_sel;

  // Stimulus shaping
  int          sender_idle_pct    = 0;
  int          receiver_stall_pct = 0;
  logic [31:0] clock_ms           = 32'd0;
  logic [31:0] last_low_stamp     = 32'd0;
  logic [31:0] last_high_stamp    = 32'd0;

  int          mismatch_count = 0;
  int          quiet_cycles   = 0;

  // --------------------------------------------------------------------------
  // Clock and DUT
  // --------------------------------------------------------------------------
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  accel_source_select_norm u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .low_accel_x_i    (drive_sample.low_x),
    .low_accel_y_i    (drive_sample.low_y),
    .low_accel_z_i    (drive_sample.low_z),
    .low_time_ms_i    (drive_sample.low_t),
    .high_accel_x_i   (drive_sample.high_x),
    .high_accel_y_i   (drive_sample.high_y),
    .high_accel_z_i   (drive_sample.high_z),
    .high_time_ms_i   (drive_sample.high_t),
    .high_status_i    (drive_sample.status),
    .high_health_ok_i (drive_sample.health),
    .now_ms_i         (drive_sample.now),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .source_o         (source_o),
    .sample_time_o    (sample_time_o),
    .norm_g_o         (norm_g_o)
  );

  // --------------------------------------------------------------------------
  // Model of the selector
  // --------------------------------------------------------------------------

  // Exact square of a two's complement axis; the most negative word is 2^31
  function automatic logic [63:0] axis_square(input logic [31:0] c);
    logic [63:0] mag;
    mag = c[31] ? (64'd0 - {32'hFFFF_FFFF, c}) : {32'd0, c};
    return mag * mag;
  endfunction

  // Floor square root; the sum of three squares stays below 2^64, so the
  // root always fits in 32 bits
  function automatic logic [31:0] floor_root(input logic [63:0] n);
    logic [31:0] r;
    logic [31:0] trial;
    r = 32'd0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= n) r = trial;
    end
    return r;
  endfunction

  function automatic logic [31:0] vector_length(input logic [31:0] x, input logic [31:0] y,
                                                input logic [31:0] z);
    return floor_root(axis_square(x) + axis_square(y) + axis_square(z));
  endfunction

  // Age is the modular difference; a zero stamp means no sample
  function automatic bit is_fresh(input logic [31:0] stamp, input logic [31:0] now);
    logic [31:0] age_ms;
    age_ms = now - stamp;
    return (stamp != 32'd0) && (age_ms <= {16'd0, age_limit});
  endfunction

  // Pick the source, form the magnitude in g and apply duplicate suppression.
  // Returns 1 when a result is due.
  function automatic bit predict_selection(input imu_sample_t s, output selection_t sel);
    logic [63:0]      in_g;
    asnorm_pkg::src_e pick;
    sel = '{source: 1'b0, stamp: 32'd0, norm: 32'd0};
    if (is_fresh(s.low_t, s.now)) begin
      pick      = asnorm_pkg::SRC_LOW;
      sel.stamp = s.low_t;
      in_g      = 64'(vector_length(s.low_x, s.low_y, s.low_z)) * G_SCALE_NUM / G_SCALE_DEN;
      sel.norm  = (in_g > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : in_g[31:0];
    end else if (s.health && (s.status & STAT_READY) == STAT_READY &&
                 is_fresh(s.high_t, s.now)) begin
      pick      = asnorm_pkg::SRC_HIGH;
      sel.stamp = s.high_t;
      sel.norm  = vector_length(s.high_x, s.high_y, s.high_z);
    end else begin
      return 1'b0;
    end
    // Drop a repeat of the last emission; no fallback to the other sensor
    if (pick == emitted_source && sel.stamp == emitted_stamp) return 1'b0;
    emitted_source = pick;
    emitted_stamp  = sel.stamp;
    sel.source     = (pick == asnorm_pkg::SRC_HIGH);
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: predict on input acceptance, check on output acceptance
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Sample on the rising edge, before the DUT's own updates land
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (predict_selection(drive_sample, accepted_sel))
        expected_selections.push_back(accepted_sel);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_selections.size() == 0) begin
        report_mismatch("result with nothing expected", sample_time_o, 32'd0);
      end else begin
        oldest_sel = expected_selections.pop_front();
        if (source_o !== oldest_sel.source)
          report_mismatch("source", 32'(source_o), 32'(oldest_sel.source));
        if (sample_time_o !== oldest_sel.stamp)
          report_mismatch("sample_time", sample_time_o, oldest_sel.stamp);
        if (norm_g_o !== oldest_sel.norm)
          report_mismatch("norm_g", norm_g_o, oldest_sel.norm);
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Watchdog: count cycles in which neither channel moves a transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $realtime, quiet_cycles);
        $display("accel_source_select_norm regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks; each is entered and left on a falling edge
  // --------------------------------------------------------------------------

  // Present one transaction, with optional idle gap, and hold it until taken
  task automatic send_item(input imu_sample_t s);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    drive_sample <= s;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Hold the input idle until every prediction has been matched, then settle
  task automatic wait_drain(input int settle);
    in_valid_i <= 1'b0;
    while (expected_selections.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write the age limit only once the block has gone quiet
  task automatic set_max_age(input logic [15:0] ms);
    wait_drain(DRAIN_CYCLES);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ms;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    age_limit  = ms;
  endtask

  function automatic imu_sample_t imu_sample(
      input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
      input logic [31:0] lt, input logic [31:0] hx, input logic [31:0] hy,
      input logic [31:0] hz, input logic [31:0] ht, input logic [1:0] st,
      input logic ok, input logic [31:0] now);
    return '{low_x: lx, low_y: ly, low_z: lz, low_t: lt, high_x: hx, high_y: hy,
             high_z: hz, high_t: ht, status: st, health: ok, now: now};
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus helpers
  // --------------------------------------------------------------------------

  // Stamp around the age boundary, with zero, future and repeated stamps
  function automatic logic [31:0] stamp_near(input logic [31:0] now, input logic [31:0] prev);
    logic [31:0] lim;
    lim = {16'd0, age_limit};
    case ($urandom_range(9))
      0, 1, 2: return now - $urandom_range(0, lim);
      3:       return now - lim - $urandom_range(0, 1);
      4:       return now - lim - 32'd1 - $urandom_range(0, 5000);
      5:       return 32'd0;
      6:       return now + $urandom_range(1, 100);
      default: return prev;
    endcase
  endfunction

  function automatic logic [31:0] random_axis();
    case ($urandom_range(7))
      0:       return AXIS_MOST_NEG;
      1:       return AXIS_MAX_POS;
      2:       return 32'd0;
      3, 4:    return $urandom;
      default: return $urandom_range(0, 2000000) - 32'd1000000;
    endcase
  endfunction

  task automatic build_random_sample(output imu_sample_t s);
    if ($urandom_range(9) == 0) begin
      // Noise: every field drawn over its whole range
      s = imu_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, 2'($urandom), 1'($urandom), $urandom);
    end else begin
      // Advance a slow clock so repeated stamps stay fresh; jump now and then,
      // sometimes to just below the wrap point
      case ($urandom_range(19))
        0:       clock_ms = $urandom;
        1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
        default: clock_ms = clock_ms + $urandom_range(0, 3);
      endcase
      s = imu_sample(random_axis(), random_axis(), random_axis(),
                     stamp_near(clock_ms, last_low_stamp),
                     random_axis(), random_axis(), random_axis(),
                     stamp_near(clock_ms, last_high_stamp),
                     ($urandom_range(9) < 7) ? STAT_READY : 2'($urandom_range(0, 3)),
                     ($urandom_range(9) < 8), clock_ms);
    end
    last_low_stamp  = s.low_t;
    last_high_stamp = s.high_t;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Low-g selection: extremes, age boundary, wrap, duplicate without fallback
  task automatic test_low_selection();
    send_item(imu_sample(AXIS_MAX_POS, AXIS_MAX_POS, AXIS_MAX_POS, 32'd1000,
                         AXIS_ONE, 0, 0, 32'd1000, STAT_READY, 1'b1, 32'd1000));
    send_item(imu_sample(AXIS_MOST_NEG, AXIS_MOST_NEG, AXIS_MOST_NEG, 32'd1001,
                         AXIS_ONE, 0, 0, 32'd1001, STAT_READY, 1'b1, 32'd1051));
    send_item(imu_sample(0, 0, 0, 32'd1002, AXIS_ONE, 0, 0, 32'd1002,
                         STAT_READY, 1'b1, 32'd1002));
    // Repeat of the last low-g emission: nothing, even with high-g on offer
    send_item(imu_sample(AXIS_ONE, 0, 0, 32'd1002, AXIS_ONE, 0, 0, 32'd1010,
                         STAT_READY, 1'b1, 32'd1010));
    // One past the age limit: fall back to high-g
    send_item(imu_sample(AXIS_ONE, 0, 0, 32'd2000, AXIS_MOST_NEG, AXIS_ONE, 0, 32'd2050,
                         STAT_READY, 1'b1, 32'd2051));
    // Future low-g stamp counts as stale
    send_item(imu_sample(AXIS_ONE, 0, 0, 32'd3001, 0, AXIS_ONE, 0, 32'd3000,
                         STAT_READY, 1'b1, 32'd3000));
    // Zero low-g stamp means no sample
    send_item(imu_sample(AXIS_ONE, 0, 0, 32'd0, 0, 0, AXIS_ONE, 32'd3005,
                         STAT_READY, 1'b1, 32'd3005));
    send_item(imu_sample(AXIS_ONE_G_NEG, 0, 0, 32'd3006, 0, 0, 0, 32'd0,
                         STAT_NONE, 1'b0, 32'd3006));
    // Age across the 32-bit wrap
    send_item(imu_sample(AXIS_ONE, AXIS_ONE_G_NEG, AXIS_ONE, 32'hFFFF_FFF0, 0, 0, 0, 32'd0,
                         STAT_NONE, 1'b0, 32'd5));
  endtask

  // High-g fallback: extremes and every disqualifying condition
  task automatic test_high_fallback();
    send_item(imu_sample(0, 0, 0, 32'd0, AXIS_MAX_POS, AXIS_MAX_POS, AXIS_MAX_POS,
                         32'd4000, STAT_READY, 1'b1, 32'd4010));
    send_item(imu_sample(0, 0, 0, 32'd0, AXIS_MOST_NEG, AXIS_MOST_NEG, AXIS_MOST_NEG,
                         32'd4011, STAT_READY, 1'b1, 32'd4011));
    // Repeat of the last high-g emission
    send_item(imu_sample(0, 0, 0, 32'd0, AXIS_ONE, 0, 0, 32'd4011,
                         STAT_READY, 1'b1, 32'd4020));
    send_item(imu_sample(0, 0, 0, 32'd0, AXIS_ONE, 0, 0, 32'd4021,
                         STAT_CONNECTED, 1'b1, 32'd4021));
    send_item(imu_sample(0, 0, 0, 32'd0, AXIS_ONE, 0, 0, 32'd4022,
                         STAT_NEW_DATA, 1'b1, 32'd4022));
    send_item(imu_sample(0, 0, 0, 32'd0, AXIS_ONE, 0, 0, 32'd4023,
                         STAT_NONE, 1'b1, 32'd4023));
    send_item(imu_sample(0, 0, 0, 32'd0, AXIS_ONE, 0, 0, 32'd4024,
                         STAT_READY, 1'b0, 32'd4024));
    send_item(imu_sample(0, 0, 0, 32'd0, AXIS_ONE, 0, 0, 32'd0,
                         STAT_READY, 1'b1, 32'd20));
    send_item(imu_sample(0, 0, 0, 32'd0, AXIS_ONE, 0, 0, 32'd4000,
                         STAT_READY, 1'b1, 32'd4051));
    send_item(imu_sample(0, 0, 0, 32'd0, AXIS_ONE, 0, 0, 32'd4101,
                         STAT_READY, 1'b1, 32'd4100));
    // Same stamp from the other source is not a repeat, either way round
    send_item(imu_sample(AXIS_ONE, AXIS_ONE, 0, 32'd4011, 0, 0, 0, 32'd0,
                         STAT_NONE, 1'b0, 32'd4011));
    send_item(imu_sample(0, 0, 0, 32'd0, AXIS_ONE, AXIS_ONE, 0, 32'd4011,
                         STAT_READY, 1'b1, 32'd4011));
  endtask

  // Age limit at both ends of the register range
  task automatic test_age_limits();
    set_max_age(16'd0);
    send_item(imu_sample(AXIS_ONE, 0, 0, 32'd7000, 0, 0, 0, 32'd0,
                         STAT_NONE, 1'b0, 32'd7000));
    send_item(imu_sample(AXIS_ONE, 0, 0, 32'd6999, 0, AXIS_ONE, 0, 32'd7000,
                         STAT_READY, 1'b1, 32'd7000));
    set_max_age(16'hFFFF);
    send_item(imu_sample(AXIS_ONE, 0, 0, 32'd1, 0, 0, 0, 32'd0,
                         STAT_NONE, 1'b0, 32'd65536));
    send_item(imu_sample(AXIS_ONE, 0, 0, 32'd1, 0, 0, AXIS_ONE, 32'd65537,
                         STAT_READY, 1'b1, 32'd65537));
  endtask

  // Random traffic under one age limit and one idle/stall pattern
  task automatic test_random_traffic(input logic [15:0] ms, input int idle_pct,
                                     input int stall_pct, input int count);
    imu_sample_t s;
    set_max_age(ms);
    clock_ms           = $urandom;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int k = 0; k < count; k++) begin
      // Now and then hold the sender until the output side has caught up
      if ($urandom_range(59) == 0) wait_drain(0);
      build_random_sample(s);
      send_item(s);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    drive_sample = imu_sample(0, 0, 0, 0, 0, 0, 0, 0, STAT_NONE, 1'b0, 0);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_low_selection();
    test_high_fallback();
    test_age_limits();
    test_random_traffic(asnorm_pkg::MaxAgeReset, 0, 0, 200);
    test_random_traffic(16'd0, 49, 0, 200);
    test_random_traffic(16'hFFFF, 0, 49, 200);
    test_random_traffic(16'($urandom_range(1, 65534)), 32, 32, 200);

    // Let the last results out, then give the block time to go quiet
    wait_drain(DRAIN_CYCLES);
    if (mismatch_count == 0) begin
      $display("accel_source_select_norm regression: pass");
    end else begin
      $display("accel_source_select_norm regression: fail");
    end
    $finish;
  end

endmodule
